/* hdl/xsr_pkg.sv */
// Shared types and constants for the xorshift1024* generator.
// Used by every module under hdl; depends on nothing.
`timescale 1ns / 1ps

package xsr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROWS    = 16;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  localparam logic [WORD_W-1:0] MULT_LO = 32'd1419247029;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_POS  = 2'd1,
    ACT_GEN  = 2'd2
  } action_t;

  // One write into the state store; a load writes one half, an update both.
  typedef struct packed {
    logic              we_lo;
    logic              we_hi;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } xsr_wr_t;

  // Shift/xor step of xorshift1024* on a 64-bit element held as two halves.
  // Returns {hi, lo} of the new element.
  function automatic logic [2*WORD_W-1:0] xs_update(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] y,
    input logic [WORD_W-1:0] z,
    input logic [WORD_W-1:0] w
  );
    logic [WORD_W-1:0] z2;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    w2 = w ^ ((w << 31) | (z >> 1));
    z2 = z ^ (z << 31);
    lo = z2 ^ x ^ ((z2 >> 11) | (w2 << 21)) ^ ((x >> 30) | (y << 2));
    hi = w2 ^ y ^ (w2 >> 11) ^ (y >> 30);
    return {hi, lo};
  endfunction

endpackage

/* hdl/xsr_state_mem.sv */
// State store: sixteen 64-bit elements kept as a low and a high 16x32 memory.
// Two registered read ports, one write port with half enables; uses xsr_pkg.
`timescale 1ns / 1ps

module xsr_state_mem import xsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ROW_W-1:0]  rd_a_row,
  input  logic [ROW_W-1:0]  rd_b_row,
  input  xsr_wr_t           wr,
  output logic [WORD_W-1:0] rd_a_lo,
  output logic [WORD_W-1:0] rd_a_hi,
  output logic [WORD_W-1:0] rd_b_lo,
  output logic [WORD_W-1:0] rd_b_hi
);

  logic [WORD_W-1:0] lo_mem [ROWS];
  logic [WORD_W-1:0] hi_mem [ROWS];

  // Per-half valid bits give the all-zero reset without a clearing pass.
  logic [ROWS-1:0] lo_vld_r;
  logic [ROWS-1:0] hi_vld_r;

  logic [WORD_W-1:0] a_lo_r, a_hi_r, b_lo_r, b_hi_r;
  logic              a_lo_v_r, a_hi_v_r, b_lo_v_r, b_hi_v_r;

  always_ff @(posedge clk) begin
    if (wr.we_lo) begin
      lo_mem[wr.row] <= wr.lo;
    end
    if (wr.we_hi) begin
      hi_mem[wr.row] <= wr.hi;
    end
    a_lo_r <= lo_mem[rd_a_row];
    a_hi_r <= hi_mem[rd_a_row];
    b_lo_r <= lo_mem[rd_b_row];
    b_hi_r <= hi_mem[rd_b_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_vld_r <= '0;
      hi_vld_r <= '0;
      a_lo_v_r <= 1'b0;
      a_hi_v_r <= 1'b0;
      b_lo_v_r <= 1'b0;
      b_hi_v_r <= 1'b0;
    end else begin
      if (wr.we_lo) begin
        lo_vld_r[wr.row] <= 1'b1;
      end
      if (wr.we_hi) begin
        hi_vld_r[wr.row] <= 1'b1;
      end
      a_lo_v_r <= lo_vld_r[rd_a_row];
      a_hi_v_r <= hi_vld_r[rd_a_row];
      b_lo_v_r <= lo_vld_r[rd_b_row];
      b_hi_v_r <= hi_vld_r[rd_b_row];
    end
  end

  assign rd_a_lo = a_lo_v_r ? a_lo_r : '0;
  assign rd_a_hi = a_hi_v_r ? a_hi_r : '0;
  assign rd_b_lo = b_lo_v_r ? b_lo_r : '0;
  assign rd_b_hi = b_hi_v_r ? b_hi_r : '0;

endmodule

/* hdl/xsr_out_queue.sv */
// Output side: registered multiply by the xorshift1024* constant, then a
// four-entry queue that absorbs back-pressure; uses xsr_pkg.
`timescale 1ns / 1ps

module xsr_out_queue import xsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WORD_W-1:0] push_lo,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_random_word
);

  logic              prod_vld_r;
  logic [WORD_W-1:0] prod_r;

  logic [WORD_W-1:0]  q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    prod_r <= WORD_W'(push_lo * MULT_LO);
    if (prod_vld_r) begin
      q_mem_r[wr_ptr_r] <= prod_r;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (prod_vld_r && !pop) begin
      cnt_nxt = Q_CNT_W'(cnt_r + 1'b1);
    end else if (!prod_vld_r && pop) begin
      cnt_nxt = Q_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      prod_vld_r <= push;
      if (prod_vld_r) begin
        wr_ptr_r <= Q_PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= Q_PTR_W'(rd_ptr_r + 1'b1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid       = (cnt_r != '0);
  assign out_random_word = q_mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    prod_vld_r && !pop |-> cnt_r != Q_CNT_W'(Q_DEPTH))
    else $error("result queue written while full");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !prod_vld_r |=> cnt_r == Q_CNT_W'($past(cnt_r) - 1'b1))
    else $error("queue count did not fall on a lone pop");

endmodule

/* hdl/xorshift1024_star_generator.sv */
// Top level of the xorshift1024* generator: pair pointer, read-update-write
// stage with forwarding, state store and output queue; uses xsr_pkg.
`timescale 1ns / 1ps

// One beat is taken every clock cycle, loads, position sets and generates
// alike, as long as fewer than four random words are waiting or in flight.
// A generate reads two elements from the dual-read state store at the accept
// edge, updates and writes back in the following cycle, and its random word
// is offered once the constant multiply has been registered and the word
// has entered the output queue. Back-to-back generates that touch the
// element just written are served by forwarding from the write stage. The
// store reads as all zeros straight after reset; no clearing pass is needed.
module xorshift1024_star_generator import xsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [IDX_W-1:0]  in_word_index,
  input  logic [WORD_W-1:0] in_word_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_random_word
);

  logic in_fire, is_gen, is_load, is_pos;

  logic [ROW_W-1:0] ptr_r, ptr_nxt;
  logic [ROW_W-1:0] rd_a_row, rd_b_row;

  // Write stage.
  logic              s1_vld_r;
  logic              s1_gen_r;
  logic              s1_half_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [WORD_W-1:0] s1_val_r;

  // Forwarding of the write that lands at the same edge as the read.
  logic              fa_lo_r, fa_hi_r, fb_lo_r, fb_hi_r;
  logic [WORD_W-1:0] fwd_lo_r, fwd_hi_r;

  logic [WORD_W-1:0] m_a_lo, m_a_hi, m_b_lo, m_b_hi;
  logic [WORD_W-1:0] x, y, z, w;
  logic [2*WORD_W-1:0] upd;
  xsr_wr_t           wr;

  logic [Q_CNT_W-1:0] pend_r;
  logic               pop;

  assign pop     = out_valid && out_ready;
  assign in_ready = (pend_r != Q_CNT_W'(Q_DEPTH));
  assign in_fire = in_valid && in_ready;

  always_comb begin
    is_gen  = 1'b0;
    is_load = 1'b0;
    is_pos  = 1'b0;
    unique case (action_t'(in_action))
      ACT_LOAD: is_load = 1'b1;
      ACT_POS:  is_pos  = 1'b1;
      ACT_GEN:  is_gen  = 1'b1;
      default:  ;
    endcase
  end

  assign rd_a_row = ptr_r;
  assign rd_b_row = ROW_W'(ptr_r + 1'b1);

  always_comb begin
    ptr_nxt = ptr_r;
    if (in_fire && is_gen) begin
      ptr_nxt = rd_b_row;
    end else if (in_fire && is_pos) begin
      ptr_nxt = in_word_index[IDX_W-1:1];
    end
  end

  // Operands after forwarding.
  assign x = fa_lo_r ? fwd_lo_r : m_a_lo;
  assign y = fa_hi_r ? fwd_hi_r : m_a_hi;
  assign z = fb_lo_r ? fwd_lo_r : m_b_lo;
  assign w = fb_hi_r ? fwd_hi_r : m_b_hi;

  assign upd = xs_update(x, y, z, w);

  always_comb begin
    wr.row = s1_row_r;
    if (s1_gen_r) begin
      wr.we_lo = s1_vld_r;
      wr.we_hi = s1_vld_r;
      wr.lo    = upd[WORD_W-1:0];
      wr.hi    = upd[2*WORD_W-1:WORD_W];
    end else begin
      wr.we_lo = s1_vld_r && !s1_half_r;
      wr.we_hi = s1_vld_r && s1_half_r;
      wr.lo    = s1_val_r;
      wr.hi    = s1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_half_r <= in_word_index[0];
    s1_val_r  <= in_word_value;
    s1_row_r  <= is_gen ? rd_b_row : in_word_index[IDX_W-1:1];
    fwd_lo_r  <= wr.lo;
    fwd_hi_r  <= wr.hi;
    fa_lo_r   <= wr.we_lo && (wr.row == rd_a_row);
    fa_hi_r   <= wr.we_hi && (wr.row == rd_a_row);
    fb_lo_r   <= wr.we_lo && (wr.row == rd_b_row);
    fb_hi_r   <= wr.we_hi && (wr.row == rd_b_row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      s1_vld_r <= 1'b0;
      s1_gen_r <= 1'b0;
      pend_r   <= '0;
    end else begin
      ptr_r    <= ptr_nxt;
      s1_vld_r <= in_fire && (is_gen || is_load);
      s1_gen_r <= is_gen;
      if (in_fire && is_gen && !pop) begin
        pend_r <= Q_CNT_W'(pend_r + 1'b1);
      end else if (!(in_fire && is_gen) && pop) begin
        pend_r <= Q_CNT_W'(pend_r - 1'b1);
      end
    end
  end

  xsr_state_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_a_row (rd_a_row),
    .rd_b_row (rd_b_row),
    .wr       (wr),
    .rd_a_lo  (m_a_lo),
    .rd_a_hi  (m_a_hi),
    .rd_b_lo  (m_b_lo),
    .rd_b_hi  (m_b_hi)
  );

  xsr_out_queue u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (s1_vld_r && s1_gen_r),
    .push_lo         (upd[WORD_W-1:0]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word)
  );

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= Q_CNT_W'(Q_DEPTH))
    else $error("more random words outstanding than the queue holds");

  a_gen_steps_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_gen |=> ptr_r == ROW_W'($past(ptr_r) + 1'b1) && s1_vld_r && s1_gen_r)
    else $error("generate beat did not advance the pair pointer");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("random word offered with nothing outstanding");

endmodule
